[rtl/core/pma_pkg.sv]
// Shared constants for the primed moving average unit.
`timescale 1ns / 1ps

package pma_pkg;

  localparam int WINDOW_LEN = 8;
  localparam int SAMPLE_W   = 16;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam slot_t LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  function automatic sample_t slot_quot(input sample_t s);
    return sample_t'(s / WINDOW_LEN);
  endfunction

endpackage

[rtl/core/pma_window.sv]
// Window of per-slot quotients with a running sum of quotients.
`timescale 1ns / 1ps

module pma_window
  import pma_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  sample_t sample,
  output sample_t sum_next
);

  sample_t quot [WINDOW_LEN];
  sample_t acc;
  slot_t   slot;
  logic    primed;

  sample_t q_new;
  sample_t q_old;
  logic [SAMPLE_W+SLOT_W:0] fill_sum;

  assign q_new    = slot_quot(sample);
  assign q_old    = quot[slot];
  assign fill_sum = (SAMPLE_W + SLOT_W + 1)'(WINDOW_LEN) * (SAMPLE_W + SLOT_W + 1)'(q_new);

  always_comb begin
    if (!primed) begin
      sum_next = fill_sum[SAMPLE_W-1:0];
    end else begin
      sum_next = acc - q_old + q_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!primed) begin
        for (int k = 0; k < WINDOW_LEN; k++) begin
          quot[k] <= q_new;
        end
      end else begin
        quot[slot] <= q_new;
      end
      acc <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      primed <= 1'b0;
    end else if (en) begin
      primed <= 1'b1;
      if (primed) begin
        slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      end
    end
  end

  a_slot_zero_until_primed: assert property (@(posedge clk) disable iff (rst)
    !primed |-> slot == '0)
    else $error("write slot moved before the window was primed");

  a_first_primes: assert property (@(posedge clk) disable iff (rst)
    en |=> primed)
    else $error("window not primed after a request");

  a_primed_stays: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped without reset");

endmodule

[rtl/core/primed_moving_average_unit.sv]
// Top level: stream ports, input and result registers around the window.
`timescale 1ns / 1ps

// Primed moving average over the last WINDOW_LEN 16-bit samples. Each
// request gives one average; the first sample after reset fills the whole
// window. Requests pass input and result registers, one per cycle unless
// the output stalls: the per-slot quotient store keeps a running sum, so
// each step is one subtract and one add. The result register lets a new
// request in while a finished average waits on the output.
module primed_moving_average_unit
  import pma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [15:0] average
);

  logic    s_valid;
  sample_t s_sample;
  logic    o_valid;
  sample_t o_data;
  logic    advance;
  sample_t sum_next;

  assign advance       = s_valid && (!o_valid || m_axis_tready);
  assign s_axis_tready = !s_valid || advance;
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_data;

  pma_window u_window (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .sample   (s_sample),
    .sum_next (sum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s_valid <= s_axis_tvalid;
      end
      if (advance) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s_sample <= s_axis_tdata;
    end
    if (advance) begin
      o_data <= sum_next;
    end
  end

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> o_valid)
    else $error("result register empty after advance");

  a_held_request_stable: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !advance) |=> (s_valid && $stable(s_sample)))
    else $error("held request lost or changed");

  a_empty_input_ready: assert property (@(posedge clk) disable iff (rst)
    !s_valid |-> s_axis_tready)
    else $error("empty input register not ready");

endmodule
